// ===== sv/u8u16_pkg.sv =====
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types for the UTF-8 to UTF-16 decoder: beat structs and result kinds.
// ----------------------------------------------------------------------------
package u8u16_pkg;

    // Kind of one result beat.
    typedef enum logic [1:0] {
        KIND_UNIT = 2'd0,
        KIND_OK   = 2'd1,
        KIND_BAD  = 2'd2
    } kind_t;

    // One incoming beat: a raw UTF-8 byte and the end-of-string flag.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_string;
    } in_beat_t;

    // One outgoing beat: a UTF-16 unit or a string marker.
    typedef struct packed {
        logic [15:0] code_unit;
        kind_t       kind;
        logic        last_of_run;
    } out_beat_t;

    // Most results one byte can cause: two surrogate units and a marker.
    localparam int unsigned MAX_RESULTS = 3;

    localparam logic [20:0] SURR_LO   = 21'h00D800;
    localparam logic [20:0] SURR_HI   = 21'h00DFFF;
    localparam logic [20:0] CODE_MAX  = 21'h10FFFF;
    localparam logic [20:0] BMP_MAX   = 21'h00FFFF;
    localparam logic [20:0] SUPP_BASE = 21'h010000;
    localparam logic [5:0]  HIGH_TAG  = 6'b110110;
    localparam logic [5:0]  LOW_TAG   = 6'b110111;

endpackage

// ===== sv/utf8_to_utf16_decoder.sv =====
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder
// Streams UTF-8 bytes in and UTF-16 code units plus end-of-string markers out.
// ----------------------------------------------------------------------------
// Path: a byte is captured in the input register, decoded from there, and its
// results are loaded into the result buffer, whose entry 0 drives the output.
// Throughput: one byte per cycle while each byte causes at most one result and the output is not
// stalled; a byte that causes two or three results holds the single output port until all
// of them have left, since results leave one per beat from the result buffer.
// Reset: rst_n clears all decoder state and both valid paths asynchronously.
// ----------------------------------------------------------------------------
module utf8_to_utf16_decoder (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  utf8_valid,
    output logic                  utf8_stall,
    input  u8u16_pkg::in_beat_t   utf8_beat,
    output logic                  utf16_valid,
    input  logic                  utf16_stall,
    output u8u16_pkg::out_beat_t  utf16_beat
);

    // Input register. It takes a new byte whenever it is empty or its byte
    // moves on into the result buffer in the same cycle, so the input side
    // keeps flowing while the last result of the previous byte waits.
    logic                 in_valid_reg;
    logic                 in_valid_next;
    u8u16_pkg::in_beat_t  in_beat_reg;

    // Decoder state, committed only when a byte is decoded.
    logic [20:0] partial_reg;
    logic [20:0] partial_next;
    logic [1:0]  due_reg;
    logic [1:0]  due_next;
    logic        disc_reg;
    logic        disc_next;
    logic        err_reg;
    logic        err_next;

    // Result buffer. Entry 0 is always the beat on the output; the rest
    // shift down as beats are taken.
    u8u16_pkg::out_beat_t  res_reg  [u8u16_pkg::MAX_RESULTS];
    u8u16_pkg::out_beat_t  res_next [u8u16_pkg::MAX_RESULTS];
    logic [1:0]            cnt_reg;
    logic [1:0]            cnt_next;

    // Results of decoding the byte in the input register.
    u8u16_pkg::out_beat_t  dec_res [u8u16_pkg::MAX_RESULTS];
    logic [1:0]            dec_n;

    logic move;
    logic pop;

    assign utf16_valid = (cnt_reg != 2'd0);
    assign utf16_beat  = res_reg[0];
    assign pop         = utf16_valid && !utf16_stall;

    // The decoded byte may load the buffer once it is empty, or once its
    // only remaining beat leaves in this cycle.
    assign move = in_valid_reg && ((cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && pop));

    assign utf8_stall    = in_valid_reg && !move;
    assign in_valid_next = (utf8_valid && !utf8_stall) || (in_valid_reg && !move);

    // Byte decoder. This mirrors the per-byte behavior: lead byte
    // classification, continuation gathering, code point checks, surrogate
    // pair split and the closing marker on the flagged byte.
    always_comb
    begin
        logic [7:0]  b;
        logic        done;
        logic [20:0] c;
        logic [20:0] cm;
        logic [1:0]  n;

        b            = in_beat_reg.in_byte;
        partial_next = partial_reg;
        due_next     = due_reg;
        disc_next    = disc_reg;
        err_next     = err_reg;
        done         = 1'b0;
        n            = 2'd0;
        c            = 21'd0;
        cm           = 21'd0;
        for (int i = 0; i < u8u16_pkg::MAX_RESULTS; i++)
        begin
            dec_res[i] = '{code_unit: 16'd0, kind: u8u16_pkg::KIND_UNIT,
                           last_of_run: 1'b0};
        end

        if (!disc_reg)
        begin
            if (due_reg == 2'd0)
            begin
                if (b == 8'h00)
                begin
                    // A zero lead byte ends the string early and correctly.
                    disc_next = 1'b1;
                end
                else if (b inside {[8'h01:8'h7F]})
                begin
                    partial_next = {13'd0, b};
                    done         = 1'b1;
                end
                else if (b inside {[8'hC0:8'hDF]})
                begin
                    partial_next = {16'd0, b[4:0]};
                    due_next     = 2'd1;
                end
                else if (b inside {[8'hE0:8'hEF]})
                begin
                    partial_next = {17'd0, b[3:0]};
                    due_next     = 2'd2;
                end
                else if (b inside {[8'hF0:8'hF7]})
                begin
                    partial_next = {18'd0, b[2:0]};
                    due_next     = 2'd3;
                end
                else
                begin
                    // Stray continuation byte or an illegal lead byte.
                    disc_next = 1'b1;
                    err_next  = 1'b1;
                end
            end
            else
            begin
                if (b inside {[8'h80:8'hBF]})
                begin
                    partial_next = {partial_reg[14:0], b[5:0]};
                    due_next     = due_reg - 2'd1;
                    done         = (due_reg == 2'd1);
                end
                else
                begin
                    disc_next = 1'b1;
                    err_next  = 1'b1;
                end
            end
        end

        if (done)
        begin
            c  = partial_next;
            cm = c - u8u16_pkg::SUPP_BASE;
            if (((c >= u8u16_pkg::SURR_LO) && (c <= u8u16_pkg::SURR_HI))
                || (c > u8u16_pkg::CODE_MAX))
            begin
                disc_next = 1'b1;
                err_next  = 1'b1;
            end
            else if (c <= u8u16_pkg::BMP_MAX)
            begin
                dec_res[0].code_unit = c[15:0];
                n = 2'd1;
            end
            else
            begin
                // Adding the surrogate bases only fills the top six bits.
                dec_res[0].code_unit = {u8u16_pkg::HIGH_TAG, cm[19:10]};
                dec_res[1].code_unit = {u8u16_pkg::LOW_TAG, cm[9:0]};
                n = 2'd2;
            end
            partial_next = 21'd0;
        end

        if (in_beat_reg.end_of_string)
        begin
            // A string cut short inside a sequence is invalid.
            if (!disc_next && (due_next != 2'd0))
            begin
                err_next = 1'b1;
            end
            dec_res[n].code_unit = 16'd0;
            dec_res[n].kind      = err_next ? u8u16_pkg::KIND_BAD : u8u16_pkg::KIND_OK;
            n = n + 2'd1;
            partial_next = 21'd0;
            due_next     = 2'd0;
            disc_next    = 1'b0;
            err_next     = 1'b0;
        end

        if (n != 2'd0)
        begin
            dec_res[n - 2'd1].last_of_run = 1'b1;
        end
        dec_n = n;
    end

    // Result buffer next value: load on a decode, shift down on a pop.
    always_comb
    begin
        cnt_next = cnt_reg;
        for (int i = 0; i < u8u16_pkg::MAX_RESULTS; i++)
        begin
            res_next[i] = res_reg[i];
        end
        if (move)
        begin
            cnt_next = dec_n;
            for (int i = 0; i < u8u16_pkg::MAX_RESULTS; i++)
            begin
                res_next[i] = dec_res[i];
            end
        end
        else if (pop)
        begin
            cnt_next    = cnt_reg - 2'd1;
            res_next[0] = res_reg[1];
            res_next[1] = res_reg[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            cnt_reg      <= 2'd0;
            partial_reg  <= 21'd0;
            due_reg      <= 2'd0;
            disc_reg     <= 1'b0;
            err_reg      <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            cnt_reg      <= cnt_next;
            if (move)
            begin
                partial_reg <= partial_next;
                due_reg     <= due_next;
                disc_reg    <= disc_next;
                err_reg     <= err_next;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (utf8_valid && !utf8_stall)
        begin
            in_beat_reg <= utf8_beat;
        end
        for (int i = 0; i < u8u16_pkg::MAX_RESULTS; i++)
        begin
            res_reg[i] <= res_next[i];
        end
    end

    // A marker is always the final result of its byte.
    a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
        (utf16_valid && (utf16_beat.kind != u8u16_pkg::KIND_UNIT))
        |-> utf16_beat.last_of_run)
        else $error("marker beat without last_of_run");

    // The buffer never loads while more than one earlier result is waiting.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg > 2'd1) |-> !move)
        else $error("result buffer loaded over pending results");

    // A stalled input side always means a byte is held in the input register.
    a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
        utf8_stall |-> in_valid_reg)
        else $error("input stalled with empty input register");

    // A beat taken with more behind it leaves the next one on the output.
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !move && (cnt_reg > 2'd1)) |=> utf16_valid)
        else $error("result buffer lost a pending beat");

endmodule
